### rtl/slip_frame_decoder_defines.svh
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef SLIP_FRAME_DECODER_DEFINES_SVH
`define SLIP_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define SFD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define SFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SFD_ASSERT_IMPL(label, ante, cons, msg)

`define SFD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### rtl/sfd_pkg.sv
package sfd_pkg;

	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	localparam int BYTE_W   = 8;
	localparam int PHASE_W  = 3;
	localparam int STATUS_W = 2;

	localparam logic [PHASE_W-1:0] PH_HUNT = 3'd0;
	localparam logic [PHASE_W-1:0] PH_OPEN = 3'd1;
	localparam logic [PHASE_W-1:0] PH_BODY = 3'd2;
	localparam logic [PHASE_W-1:0] PH_ESC  = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DROP = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_ESC   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ESC_CLOSE = 2'd2;

endpackage

### rtl/slip_frame_decoder.sv
// SLIP receiver: one raw line byte per request on the slave side, at most one decoded
// request on the master side. Bytes before an opening 0xC0 are discarded, back-to-back
// delimiters never form an empty frame, and escapes are undone. Each payload byte is
// given with tlast low; the closing delimiter gives one request with tlast high, data
// zero and the frame status in tuser (0 ok, 1 unknown escaped code, 2 escape directly
// before the close); after an error the rest of the frame is dropped. The block takes
// one byte every cycle; a taken byte passes through an input register and then an output
// register, and only a stalled master side slows the intake.
`include "slip_frame_decoder_defines.svh"

module slip_frame_decoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [sfd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [sfd_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] data_byte
	output logic                         m_tlast,
	output logic [sfd_pkg::STATUS_W-1:0] m_tuser    // [1:0] frame_status
);
	import sfd_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                valid_s2;
	logic [BYTE_W-1:0]   data_s2;
	logic                last_s2;
	logic [STATUS_W-1:0] status_s2;
	logic [PHASE_W-1:0]  phase_q;
	logic [STATUS_W-1:0] err_q;

	logic                out_free;
	logic                consume;
	logic [PHASE_W-1:0]  phase_d;
	logic [STATUS_W-1:0] err_d;
	logic                res;
	logic [BYTE_W-1:0]   res_data;
	logic                res_last;
	logic [STATUS_W-1:0] res_status;

	assign out_free = !valid_s2 || m_tready;
	assign consume  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_comb begin
		phase_d    = phase_q;
		err_d      = err_q;
		res        = 1'b0;
		res_data   = '0;
		res_last   = 1'b0;
		res_status = ST_OK;
		case (phase_q)
			PH_OPEN, PH_BODY: begin
				if (byte_s1 == SLIP_END) begin
					if (phase_q == PH_BODY) begin
						res        = 1'b1;
						res_last   = 1'b1;
						res_status = ST_OK;
						phase_d    = PH_HUNT;
						err_d      = ST_OK;
					end
				end else if (byte_s1 == SLIP_ESC) begin
					phase_d = PH_ESC;
				end else begin
					phase_d  = PH_BODY;
					res      = 1'b1;
					res_data = byte_s1;
				end
			end
			PH_ESC: begin
				if (byte_s1 == SLIP_END) begin
					res        = 1'b1;
					res_last   = 1'b1;
					res_status = ST_ESC_CLOSE;
					phase_d    = PH_HUNT;
					err_d      = ST_OK;
				end else if (byte_s1 == SLIP_ESC_END) begin
					phase_d  = PH_BODY;
					res      = 1'b1;
					res_data = SLIP_END;
				end else if (byte_s1 == SLIP_ESC_ESC) begin
					phase_d  = PH_BODY;
					res      = 1'b1;
					res_data = SLIP_ESC;
				end else begin
					phase_d = PH_DROP;
					err_d   = ST_BAD_ESC;
				end
			end
			PH_DROP: begin
				if (byte_s1 == SLIP_END) begin
					res        = 1'b1;
					res_last   = 1'b1;
					res_status = err_q;
					phase_d    = PH_HUNT;
					err_d      = ST_OK;
				end
			end
			default: begin
				if (byte_s1 == SLIP_END) begin
					phase_d = PH_OPEN;
					err_d   = ST_OK;
				end else begin
					phase_d = PH_HUNT;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			phase_q  <= PH_HUNT;
			err_q    <= ST_OK;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= consume && res;
			end
			if (consume) begin
				phase_q <= phase_d;
				err_q   <= err_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
		if (consume && res) begin
			data_s2   <= res_data;
			last_s2   <= res_last;
			status_s2 <= res_status;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tlast  = last_s2;
	assign m_tuser  = status_s2;

	`SFD_ASSERT_IMPL(a_end_has_no_data, valid_s2 && last_s2, data_s2 == '0,
		"end-of-frame request carries nonzero data")
	`SFD_ASSERT_IMPL(a_data_has_ok_status, valid_s2 && !last_s2, status_s2 == ST_OK,
		"payload request carries a status")
	`SFD_ASSERT_IMPL(a_error_only_when_dropping, err_q != ST_OK, phase_q == PH_DROP,
		"error status latched outside the drop phase")
	`SFD_ASSERT_NEXT(a_close_returns_to_hunt, consume && res && res_last,
		phase_q == PH_HUNT && err_q == ST_OK, "close did not return to hunting")
	`SFD_ASSERT_NEXT(a_held_byte_kept, valid_s1 && !out_free,
		valid_s1 && $stable(byte_s1), "stalled input byte was lost")

endmodule

### tb/slip_frame_decoder_checker.sv
module slip_frame_decoder_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	input  logic [sfd_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] rx_byte
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic [sfd_pkg::BYTE_W-1:0]   m_tdata,   // [7:0] data_byte
	input  logic                         m_tlast,
	input  logic [sfd_pkg::STATUS_W-1:0] m_tuser,   // [1:0] frame_status
	output int                           fail_count,
	output int                           open_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import sfd_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0]   data;
		logic                last;
		logic [STATUS_W-1:0] status;
	} decoded_t;

	decoded_t            decoded_q[$];
	logic [PHASE_W-1:0]  line_phase;
	logic [STATUS_W-1:0] held_status;
	int                  errs;

	// Advances the receiver phase by one line byte; returns 1 when a request is due.
	function automatic bit decode_line_byte(input logic [BYTE_W-1:0] b, output decoded_t res);
		res = '0;
		case (line_phase)
			PH_OPEN, PH_BODY: begin
				if (b == SLIP_END) begin
					if (line_phase == PH_OPEN)
						return 0;
					res.last = 1'b1;
					res.status = ST_OK;
					line_phase = PH_HUNT;
					held_status = ST_OK;
					return 1;
				end
				if (b == SLIP_ESC) begin
					line_phase = PH_ESC;
					return 0;
				end
				line_phase = PH_BODY;
				res.data = b;
				return 1;
			end
			PH_ESC: begin
				if (b == SLIP_END) begin
					res.last = 1'b1;
					res.status = ST_ESC_CLOSE;
					line_phase = PH_HUNT;
					held_status = ST_OK;
					return 1;
				end
				if (b == SLIP_ESC_END || b == SLIP_ESC_ESC) begin
					line_phase = PH_BODY;
					res.data = (b == SLIP_ESC_END) ? SLIP_END : SLIP_ESC;
					return 1;
				end
				held_status = ST_BAD_ESC;
				line_phase = PH_DROP;
				return 0;
			end
			PH_DROP: begin
				if (b != SLIP_END)
					return 0;
				res.last = 1'b1;
				res.status = held_status;
				line_phase = PH_HUNT;
				held_status = ST_OK;
				return 1;
			end
			default: begin
				line_phase = PH_HUNT;
				if (b == SLIP_END) begin
					line_phase = PH_OPEN;
					held_status = ST_OK;
				end
				return 0;
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		decoded_t res;
		decoded_t want;
		if (!arst_n) begin
			decoded_q.delete();
			line_phase = PH_HUNT;
			held_status = ST_OK;
			errs = 0;
			fail_count <= 0;
			open_count <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				if (decode_line_byte(s_tdata, res))
					decoded_q = {decoded_q, res};
			end
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					$display("%0t: unexpected request: data %02h last %0b status %0d",
						$time, m_tdata, m_tlast, m_tuser);
					errs++;
				end else begin
					want = decoded_q.pop_front();
					if (m_tdata !== want.data) begin
						$display("%0t: data mismatch: expected %02h, actual %02h",
							$time, want.data, m_tdata);
						errs++;
					end
					if (m_tlast !== want.last) begin
						$display("%0t: end flag mismatch: expected %0b, actual %0b",
							$time, want.last, m_tlast);
						errs++;
					end
					if (m_tuser !== want.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, m_tuser);
						errs++;
					end
				end
			end
			fail_count <= errs;
			open_count <= decoded_q.size();
		end
	end

endmodule

### tb/slip_frame_decoder_test.sv
module slip_frame_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sfd_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [BYTE_W-1:0]   s_tdata;   // [7:0] rx_byte
	logic                m_tvalid;
	logic                m_tready;
	logic [BYTE_W-1:0]   m_tdata;   // [7:0] data_byte
	logic                m_tlast;
	logic [STATUS_W-1:0] m_tuser;   // [1:0] frame_status

	int fail_count;
	int open_count;
	int sent_count;
	int rx_cycle;
	bit gaps_on;
	bit paused_mid;

	slip_frame_decoder dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	slip_frame_decoder_checker frame_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.fail_count(fail_count),
		.open_count(open_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// The receiver keeps its own cycle count: a stretch that is always ready, then a
	// long hold-off while the sender keeps offering bytes.
	initial begin
		m_tready <= 1'b0;
		rx_cycle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle >= 500 && rx_cycle < 800)
				m_tready <= 1'b0;
			else if (rx_cycle >= 100 && rx_cycle < 300)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(0, 99) >= 13);
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		if (gaps_on && $urandom_range(0, 99) < 13) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		sent_count++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (open_count != 0);
	endtask

	task automatic send_random_frame();
		int len;
		int pick;
		if ($urandom_range(0, 99) < 8) begin
			repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
			return;
		end
		send_byte(SLIP_END);
		while ($urandom_range(0, 99) < 15)
			send_byte(SLIP_END);
		len = $urandom_range(0, 10);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				send_byte(SLIP_ESC);
				send_byte(SLIP_ESC_END);
			end else if (pick < 24) begin
				send_byte(SLIP_ESC);
				send_byte(SLIP_ESC_ESC);
			end else if (pick < 27) begin
				send_byte(SLIP_ESC);
				send_byte(BYTE_W'($urandom_range(0, 255)));
			end else if (pick < 29) begin
				send_byte(SLIP_ESC);
				break;
			end else begin
				send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end
		send_byte(SLIP_END);
	endtask

	initial begin
		logic [BYTE_W-1:0] opening_seq[24];
		opening_seq = '{
			8'hFF, 8'h00,
			SLIP_END, SLIP_END, SLIP_END,
			8'h00, 8'hFF, 8'h7F,
			SLIP_ESC, SLIP_ESC_END, SLIP_ESC, SLIP_ESC_ESC,
			SLIP_END,
			SLIP_END, SLIP_ESC, SLIP_END,
			SLIP_END, 8'h41, SLIP_ESC, 8'h55, 8'h77, SLIP_END,
			SLIP_ESC_END, SLIP_ESC_ESC
		};
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		sent_count = 0;
		gaps_on = 1'b1;
		paused_mid = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening_seq[i])
			send_byte(opening_seq[i]);
		wait_drained();

		while (sent_count < 1050) begin
			if (!paused_mid && sent_count >= 850) begin
				wait_drained();
				paused_mid = 1'b1;
			end
			gaps_on = !(sent_count >= 600 && sent_count < 800);
			send_random_frame();
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && open_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
